FILE: rtl/rbct_pkg.sv
package rbct_pkg;

	// operation codes carried on s_tuser
	typedef enum logic [2:0] {
		OP_APPEND     = 3'd0,
		OP_SPEC_START = 3'd1,
		OP_SPEC_BYTE  = 3'd2,
		OP_COMMIT     = 3'd3,
		OP_CLEAR_TAIL = 3'd4,
		OP_REPORT     = 3'd5,
		OP_RESET      = 3'd6,
		OP_READ       = 3'd7
	} op_t;

	localparam int CAP_W  = 13;
	localparam int POS_W  = 12;
	localparam int WRAP_W = 32;
	localparam int BYTE_W = 8;

	// input transaction payload, lowest field in the lowest bits
	typedef struct packed {
		logic [2:0]        pad;
		logic [POS_W-1:0]  read_index;
		logic [WRAP_W-1:0] reader_wrap;
		logic [POS_W-1:0]  reader_tail;
		logic [CAP_W-1:0]  bytes_remaining;
		logic [BYTE_W-1:0] data_byte;
	} in_item_t;

	// result transaction payload, lowest field in the lowest bits
	typedef struct packed {
		logic [5:0]        pad;
		logic [BYTE_W-1:0] read_byte;
		logic              overflow;
		logic [CAP_W-1:0]  free_space;
		logic [WRAP_W-1:0] wrap_total;
		logic [POS_W-1:0]  head_position;
	} out_item_t;

	localparam int IN_DATA_W  = $bits(in_item_t);
	localparam int OUT_DATA_W = $bits(out_item_t);

endpackage

FILE: rtl/rbct_ram.sv
module rbct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/rbct_free.sv
module rbct_free #(
	parameter int AW = 12
) (
	input  logic [AW-1:0]                  head,
	input  logic [rbct_pkg::POS_W-1:0]     tail,
	input  logic                           tail_known,
	input  logic [rbct_pkg::CAP_W-1:0]     cap,
	output logic [rbct_pkg::CAP_W-1:0]     free_space
);

	localparam int CW = (AW > rbct_pkg::CAP_W) ? AW : rbct_pkg::CAP_W;

	logic [CW-1:0] head_ext;
	logic [CW-1:0] tail_ext;
	logic [CW-1:0] cap_ext;
	logic [CW-1:0] span;
	logic [CW-1:0] free_ext;

	assign head_ext = CW'(head);
	assign tail_ext = CW'(tail);
	assign cap_ext  = CW'(cap);

	// free bytes between committed head and oldest reader tail
	always_comb begin
		span     = '0;
		free_ext = cap_ext;
		if (tail_known) begin
			if (head_ext >= tail_ext) begin
				span     = head_ext - tail_ext;
				free_ext = (span >= cap_ext) ? '0 : cap_ext - span;
			end else begin
				span     = tail_ext - head_ext;
				free_ext = (span > cap_ext) ? cap_ext : span;
			end
		end
	end

	assign free_space = free_ext[rbct_pkg::CAP_W-1:0];

endmodule

FILE: rtl/rbct_state.sv
module rbct_state #(
	parameter int AW = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  rbct_pkg::op_t                     op,
	input  rbct_pkg::in_item_t                item,
	input  logic [rbct_pkg::CAP_W-1:0]        cap,
	output logic [AW-1:0]                     head,
	output logic [rbct_pkg::WRAP_W-1:0]       wrap_total,
	output logic [rbct_pkg::POS_W-1:0]        tail,
	output logic                              tail_known,
	output logic                              mem_we,
	output logic [AW-1:0]                     mem_waddr
);

	localparam int CW = ((AW > rbct_pkg::CAP_W) ? AW : rbct_pkg::CAP_W) + 1;

	logic [AW-1:0]                 head_q, head_d;
	logic [AW-1:0]                 spec_q, spec_d;
	logic [rbct_pkg::WRAP_W-1:0]   wrap_q, wrap_d;
	logic [rbct_pkg::POS_W-1:0]    tail_q, tail_d;
	logic [rbct_pkg::WRAP_W-1:0]   twrap_q, twrap_d;
	logic                          known_q, known_d;
	logic [CW-1:0]                 head_inc;
	logic [CW-1:0]                 spec_inc;
	logic [CW-1:0]                 cap_ext;
	logic                          take_report;

	assign head_inc = CW'(head_q) + CW'(1);
	assign spec_inc = CW'(spec_q) + CW'(1);
	assign cap_ext  = CW'(cap);

	// a reader report replaces the kept tail when it is older or no tail is kept
	assign take_report = !known_q
		|| (item.reader_wrap < twrap_q)
		|| ((item.reader_wrap == twrap_q) && (item.reader_tail < tail_q));

	// next state per operation
	always_comb begin
		head_d    = head_q;
		spec_d    = spec_q;
		wrap_d    = wrap_q;
		tail_d    = tail_q;
		twrap_d   = twrap_q;
		known_d   = known_q;
		mem_we    = 1'b0;
		mem_waddr = head_q;
		case (op)
			rbct_pkg::OP_APPEND: begin
				mem_we = accept;
				if (head_inc >= cap_ext) begin
					head_d = '0;
					wrap_d = wrap_q + rbct_pkg::WRAP_W'(1);
				end else begin
					head_d = head_inc[AW-1:0];
				end
			end
			rbct_pkg::OP_SPEC_START: begin
				spec_d = head_q;
			end
			rbct_pkg::OP_SPEC_BYTE: begin
				mem_we    = accept;
				mem_waddr = spec_q;
				spec_d    = (spec_inc >= cap_ext) ? '0 : spec_inc[AW-1:0];
			end
			rbct_pkg::OP_COMMIT: begin
				if (spec_q < head_q) begin
					wrap_d = wrap_q + rbct_pkg::WRAP_W'(1);
				end
				head_d = spec_q;
			end
			rbct_pkg::OP_CLEAR_TAIL: begin
				known_d = 1'b0;
				tail_d  = '0;
				twrap_d = '0;
			end
			rbct_pkg::OP_REPORT: begin
				if (take_report) begin
					known_d = 1'b1;
					tail_d  = item.reader_tail;
					twrap_d = item.reader_wrap;
				end
			end
			rbct_pkg::OP_RESET: begin
				head_d  = '0;
				wrap_d  = '0;
				known_d = 1'b0;
				tail_d  = '0;
				twrap_d = '0;
			end
			default: begin
			end
		endcase
	end

	// state registers, updated on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			spec_q  <= '0;
			wrap_q  <= '0;
			tail_q  <= '0;
			twrap_q <= '0;
			known_q <= 1'b0;
		end else if (accept) begin
			head_q  <= head_d;
			spec_q  <= spec_d;
			wrap_q  <= wrap_d;
			tail_q  <= tail_d;
			twrap_q <= twrap_d;
			known_q <= known_d;
		end
	end

	assign head       = head_q;
	assign wrap_total = wrap_q;
	assign tail       = tail_q;
	assign tail_known = known_q;

endmodule

FILE: rtl/ring_buffer_commit_tail_track.sv
// Byte ring buffer with speculative writes and oldest-reader tracking. One
// operation is taken per clock cycle unless the result side stalls, as a
// new operation is accepted in the same cycle as the previous result is
// taken; its result appears in the following cycle. Head, wrap count and
// free space are read straight from the state registers, and the free space
// check for appends uses the state before the append. Reads come from the
// registered read port of a single-port-write byte RAM of BUFFER_DEPTH
// entries; no clearing pass is run, and reading a slot never written gives
// an unspecified byte. buffer_capacity is clamped to 1..BUFFER_DEPTH, at
// most 8191, when written and must only change while the block is idle.
module ring_buffer_commit_tail_track #(
	parameter int BUFFER_DEPTH = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration: buffer_capacity
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rbct_pkg::CAP_W-1:0]      cfg_data,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// data_byte, bytes_remaining, reader_tail, reader_wrap, read_index
	input  logic [rbct_pkg::IN_DATA_W-1:0]  s_tdata,
	// op
	input  logic [2:0]                      s_tuser,
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// head_position, wrap_total, free_space, overflow, read_byte
	output logic [rbct_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int XW = (AW > rbct_pkg::CAP_W) ? AW : rbct_pkg::CAP_W;
	localparam logic [rbct_pkg::CAP_W-1:0] CapReset =
		rbct_pkg::CAP_W'((BUFFER_DEPTH < 4096) ? BUFFER_DEPTH : 4096);
	localparam logic [rbct_pkg::CAP_W-1:0] CapMax =
		rbct_pkg::CAP_W'((BUFFER_DEPTH < 8191) ? BUFFER_DEPTH : 8191);

	rbct_pkg::in_item_t             item;
	rbct_pkg::op_t                  op;
	rbct_pkg::out_item_t            res;
	logic                           accept;
	logic [rbct_pkg::CAP_W-1:0]     cap_q;
	logic                           out_valid_q;
	logic                           ovf_q;
	logic                           rd_q;
	logic [AW-1:0]                  head;
	logic [rbct_pkg::WRAP_W-1:0]    wrap_total;
	logic [rbct_pkg::POS_W-1:0]     tail;
	logic                           tail_known;
	logic [rbct_pkg::CAP_W-1:0]     free_space;
	logic                           mem_we;
	logic [AW-1:0]                  mem_waddr;
	logic [XW-1:0]                  ridx_ext;
	logic [XW-1:0]                  head_ext;
	logic                           ridx_ok;
	logic                           rd_en;
	logic [rbct_pkg::BYTE_W-1:0]    mem_rdata;
	logic                           ovf_now;

	assign item     = rbct_pkg::in_item_t'(s_tdata);
	assign op       = rbct_pkg::op_t'(s_tuser);
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// capacity register, clamped to the usable range on write
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CapReset;
		end else if (cfg_valid) begin
			if (cfg_data == '0) begin
				cap_q <= rbct_pkg::CAP_W'(1);
			end else if (cfg_data > CapMax) begin
				cap_q <= CapMax;
			end else begin
				cap_q <= cfg_data;
			end
		end
	end

	rbct_state #(
		.AW (AW)
	) u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.op         (op),
		.item       (item),
		.cap        (cap_q),
		.head       (head),
		.wrap_total (wrap_total),
		.tail       (tail),
		.tail_known (tail_known),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr)
	);

	rbct_free #(
		.AW (AW)
	) u_free (
		.head       (head),
		.tail       (tail),
		.tail_known (tail_known),
		.cap        (cap_q),
		.free_space (free_space)
	);

	// read address check against the store depth
	assign ridx_ext = XW'(item.read_index);
	assign ridx_ok  = (32'(item.read_index) < 32'(BUFFER_DEPTH));
	assign rd_en    = accept && (op == rbct_pkg::OP_READ) && ridx_ok;

	rbct_ram #(
		.WIDTH (rbct_pkg::BYTE_W),
		.DEPTH (BUFFER_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (item.data_byte),
		.re    (rd_en),
		.raddr (ridx_ext[AW-1:0]),
		.rdata (mem_rdata)
	);

	// append overflow check against the state before the append
	assign ovf_now = (op == rbct_pkg::OP_APPEND)
		&& ((item.bytes_remaining >= cap_q) || (item.bytes_remaining > free_space));

	// result register: valid, overflow and read flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ovf_q       <= 1'b0;
			rd_q        <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
			ovf_q       <= ovf_now;
			rd_q        <= rd_en;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload from the state after the transaction
	assign head_ext = XW'(head);
	always_comb begin
		res               = '0;
		res.head_position = head_ext[rbct_pkg::POS_W-1:0];
		res.wrap_total    = wrap_total;
		res.free_space    = free_space;
		res.overflow      = ovf_q;
		res.read_byte     = rd_q ? mem_rdata : '0;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = res;

endmodule

FILE: tb/ring_buffer_commit_tail_track_tb.sv
module ring_buffer_commit_tail_track_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rbct_pkg::*;

	localparam int DEPTH         = 4096;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 200;
	localparam int PHASE_ITEMS   = 170;
	localparam int PHASES        = 10;
	localparam int SETTLE_CYCLES = 3;

	// one planned operation of the random stream
	typedef struct packed {
		op_t        op;
		logic [12:0] rem;
	} step_t;

	// one row of the directed table; typed rows carry their own result
	typedef struct packed {
		op_t         op;
		logic [7:0]  data;
		logic [12:0] rem;
		logic [11:0] tail;
		logic [31:0] rwrap;
		logic [11:0] idx;
		logic        typed;
		logic [11:0] w_head;
		logic [31:0] w_wrap;
		logic [12:0] w_free;
		logic        w_ovf;
		logic [7:0]  w_byte;
	} dir_row_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CAP_W-1:0]      cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [2:0]            s_tuser   = OP_APPEND;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// traffic shaping
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_seq       = 0;
	int hold_seen      = 0;
	int hold_left      = 0;

	int cycle_count    = 0;
	int mismatch_count = 0;

	// ring state as the block should hold it
	logic [7:0]  ring_store [DEPTH];
	bit          ring_written [DEPTH];
	int          written_slots [$];
	int          head          = 0;
	int          spec_ptr      = 0;
	logic [31:0] wraps         = '0;
	int          tail_min      = 0;
	logic [31:0] tail_min_wrap = '0;
	bit          tail_valid    = 1'b0;
	logic [12:0] cap_reg       = 13'd4096;

	out_item_t pending_results [$];
	step_t     plan [$];
	out_item_t got_item;
	out_item_t want_item;

	dir_row_t dir_rows [25] = '{
		'{OP_CLEAR_TAIL, 0, 0, 0, 0, 0, 1, 0, 0, 4096, 0, 0},
		'{OP_APPEND, 'hFF, 4096, 0, 0, 0, 1, 1, 0, 4096, 1, 0},
		'{OP_APPEND, 'h00, 0, 0, 0, 0, 1, 2, 0, 4096, 0, 0},
		'{OP_APPEND, 'hA5, 8191, 0, 0, 0, 1, 3, 0, 4096, 1, 0},
		'{OP_APPEND, 'h5A, 1, 0, 0, 0, 1, 4, 0, 4096, 0, 0},
		'{OP_READ, 0, 0, 0, 0, 0, 1, 4, 0, 4096, 0, 'hFF},
		'{OP_READ, 0, 0, 0, 0, 1, 1, 4, 0, 4096, 0, 'h00},
		'{OP_REPORT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_REPORT, 0, 0, 4095, 'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0},
		'{OP_APPEND, 'hC3, 4092, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_APPEND, 'h3C, 4092, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_SPEC_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_SPEC_BYTE, 'h11, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_SPEC_BYTE, 'h22, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_COMMIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_SPEC_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_APPEND, 'h44, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_APPEND, 'h55, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_COMMIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_READ, 0, 0, 0, 0, 7, 0, 0, 0, 0, 0, 0},
		'{OP_RESET, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_SPEC_BYTE, 'h33, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_REPORT, 0, 0, 4095, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_REPORT, 0, 0, 50, 0, 0, 0, 0, 0, 0, 0, 0},
		'{OP_READ, 0, 0, 0, 0, 8, 0, 0, 0, 0, 0, 0}
	};

	logic [12:0] phase_caps [PHASES] = '{4096, 0, 8191, 1, 4096, 2, 5, 17, 300, 0};

	ring_buffer_commit_tail_track #(
		.BUFFER_DEPTH(DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// capacity as the block applies it
	function automatic int cap_in_use();
		int c;
		c = int'(cap_reg);
		if (c == 0) c = 1;
		if (c > DEPTH) c = DEPTH;
		return c;
	endfunction

	// free bytes against the oldest reader tail
	function automatic int free_now();
		int c;
		int d;
		c = cap_in_use();
		if (!tail_valid) return c;
		if (head >= tail_min) begin
			d = head - tail_min;
			return (d >= c) ? 0 : c - d;
		end
		d = tail_min - head;
		return (d > c) ? c : d;
	endfunction

	task automatic store_byte(int slot, logic [7:0] b);
		ring_store[slot] = b;
		if (!ring_written[slot]) begin
			ring_written[slot] = 1'b1;
			written_slots.push_back(slot);
		end
	endtask

	task automatic forget_readers();
		tail_valid    = 1'b0;
		tail_min      = 0;
		tail_min_wrap = '0;
	endtask

	// advance the ring state by one operation and form its result
	task automatic apply_ring_op(op_t op, in_item_t d, output out_item_t r);
		int         c;
		logic       ovf;
		logic [7:0] rb;
		c   = cap_in_use();
		ovf = 1'b0;
		rb  = '0;
		case (op)
			OP_APPEND: begin
				ovf = (int'(d.bytes_remaining) >= c) || (int'(d.bytes_remaining) > free_now());
				store_byte(head, d.data_byte);
				head++;
				if (head >= c) begin
					head = 0;
					wraps++;
				end
			end
			OP_SPEC_START: spec_ptr = head;
			OP_SPEC_BYTE: begin
				store_byte(spec_ptr, d.data_byte);
				spec_ptr++;
				if (spec_ptr >= c) spec_ptr = 0;
			end
			OP_COMMIT: begin
				if (spec_ptr < head) wraps++;
				head = spec_ptr;
			end
			OP_CLEAR_TAIL: forget_readers();
			OP_REPORT: begin
				if (!tail_valid || d.reader_wrap < tail_min_wrap ||
						(d.reader_wrap == tail_min_wrap && int'(d.reader_tail) < tail_min)) begin
					tail_valid    = 1'b1;
					tail_min_wrap = d.reader_wrap;
					tail_min      = int'(d.reader_tail);
				end
			end
			OP_RESET: begin
				head  = 0;
				wraps = '0;
				forget_readers();
			end
			default: rb = ring_store[d.read_index];
		endcase
		r               = '0;
		r.head_position = 12'(head);
		r.wrap_total    = wraps;
		r.free_space    = 13'(free_now());
		r.overflow      = ovf;
		r.read_byte     = rb;
	endtask

	// offer one transaction, then log its expected result on acceptance
	task automatic send_item(op_t op, in_item_t d, bit use_want, out_item_t want);
		out_item_t res;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		apply_ring_op(op, d, res);
		if (use_want) res = want;
		pending_results.push_back(res);
	endtask

	task automatic wait_results_done();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(logic [12:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_reg = v;
	endtask

	// refill the plan: speculative runs, broken runs, append runs, singles
	task automatic fill_plan();
		int r;
		int n;
		int k;
		int c;
		int start;
		c = cap_in_use();
		r = $urandom_range(0, 99);
		if (r < 30) begin
			plan.push_back('{op: OP_SPEC_START, rem: '0});
			n = $urandom_range(1, 6);
			for (k = 0; k < n; k++) begin
				plan.push_back('{op: OP_SPEC_BYTE, rem: '0});
				if ($urandom_range(0, 99) < 15)
					plan.push_back('{op: OP_APPEND, rem: 13'($urandom_range(1, 8))});
			end
			plan.push_back('{op: OP_COMMIT, rem: '0});
		end else if (r < 40) begin
			case ($urandom_range(0, 2))
				0: plan.push_back('{op: OP_SPEC_BYTE, rem: '0});
				1: plan.push_back('{op: OP_COMMIT, rem: '0});
				default: begin
					plan.push_back('{op: OP_SPEC_START, rem: '0});
					plan.push_back('{op: OP_SPEC_BYTE, rem: '0});
				end
			endcase
		end else if (r < 65) begin
			n     = $urandom_range(1, 8);
			start = ($urandom_range(0, 3) == 0) ? $urandom_range(n, c + 2) : n;
			for (k = 0; k < n; k++) begin
				if ($urandom_range(0, 9) == 0)
					plan.push_back('{op: OP_APPEND, rem: 13'($urandom_range(0, 8191))});
				else
					plan.push_back('{op: OP_APPEND, rem: 13'(start - k)});
			end
		end else if (r < 78) begin
			plan.push_back('{op: OP_REPORT, rem: '0});
		end else if (r < 91) begin
			plan.push_back('{op: OP_READ, rem: '0});
		end else if (r < 97) begin
			plan.push_back('{op: OP_CLEAR_TAIL, rem: '0});
		end else begin
			plan.push_back('{op: OP_RESET, rem: '0});
		end
	endtask

	// random payload, with the fields the operation uses steered
	task automatic build_item(step_t st, output in_item_t d);
		int c;
		c               = cap_in_use();
		d               = '0;
		d.data_byte     = 8'($urandom);
		d.bytes_remaining = 13'($urandom);
		d.reader_tail   = 12'($urandom);
		d.reader_wrap   = $urandom;
		d.read_index    = 12'($urandom);
		case (st.op)
			OP_APPEND: d.bytes_remaining = st.rem;
			OP_REPORT: begin
				if ($urandom_range(0, 9) < 7) d.reader_tail = 12'($urandom_range(0, c - 1));
				if ($urandom_range(0, 9) < 6) d.reader_wrap = wraps - 32'($urandom_range(0, 1));
			end
			// only slots already written are read
			OP_READ: d.read_index = 12'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
			default: ;
		endcase
	endtask

	task automatic report_mismatch(string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	// result side: compare each accepted transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_item = m_tdata;
			if (pending_results.size() == 0) begin
				report_mismatch("result transaction with nothing expected");
			end else begin
				want_item = pending_results.pop_front();
				check_field("head_position", 32'(got_item.head_position), 32'(want_item.head_position));
				check_field("wrap_total", got_item.wrap_total, want_item.wrap_total);
				check_field("free_space", 32'(got_item.free_space), 32'(want_item.free_space));
				check_field("overflow", 32'(got_item.overflow), 32'(want_item.overflow));
				check_field("read_byte", 32'(got_item.read_byte), 32'(want_item.read_byte));
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_seen != hold_seq) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		in_item_t    d;
		out_item_t   want;
		step_t       st;
		dir_row_t    row;
		logic [12:0] cap_val;
		int          p;
		int          n;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset capacity
		foreach (dir_rows[i]) begin
			row               = dir_rows[i];
			d                 = '0;
			d.data_byte       = row.data;
			d.bytes_remaining = row.rem;
			d.reader_tail     = row.tail;
			d.reader_wrap     = row.rwrap;
			d.read_index      = row.idx;
			want               = '0;
			want.head_position = row.w_head;
			want.wrap_total    = row.w_wrap;
			want.free_space    = row.w_free;
			want.overflow      = row.w_ovf;
			want.read_byte     = row.w_byte;
			send_item(row.op, d, row.typed, want);
		end
		s_tvalid <= 1'b0;

		// random phases, each with its own capacity and traffic shape
		for (p = 0; p < PHASES; p++) begin
			wait_results_done();
			cap_val = phase_caps[p];
			if (p == 7) cap_val = 13'($urandom_range(3, 64));
			if (p == 9) cap_val = 13'($urandom);
			write_capacity(cap_val);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
				1: begin send_idle_pct = 45; recv_stall_pct <= 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct <= 45; end
				default: begin send_idle_pct = 13; recv_stall_pct <= 13; end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// long receiver hold-off while the sender keeps offering
				if (p == 4 && n == 40) hold_seq <= hold_seq + 1;
				// sender pause until the block has drained
				if (p == 5 && n == 80) begin
					s_tvalid <= 1'b0;
					while (pending_results.size() != 0) @(posedge clk);
				end
				if (plan.size() == 0) fill_plan();
				st = plan.pop_front();
				build_item(st, d);
				send_item(st.op, d, 1'b0, '0);
			end
			s_tvalid <= 1'b0;
		end

		wait_results_done();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: ring_buffer_commit_tail_track.f
rtl/rbct_pkg.sv
rtl/rbct_ram.sv
rtl/rbct_free.sv
rtl/rbct_state.sv
rtl/ring_buffer_commit_tail_track.sv
tb/ring_buffer_commit_tail_track_tb.sv
